@@ src/tcpct_pkg.sv @@
// Shared types and constants of the TCP connection tracker.
// No dependencies; every other file imports this package.
package tcpct_pkg;

  localparam int QUEUE_DEPTH = 2;

  // command codes of an input transaction
  localparam logic [1:0] CMD_SEGMENT = 2'd0;
  localparam logic [1:0] CMD_TIMEOUT = 2'd1;
  localparam logic [1:0] CMD_LOCAL   = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  // result status codes
  localparam logic [2:0] STS_OK         = 3'd0;
  localparam logic [2:0] STS_SHORT      = 3'd1;
  localparam logic [2:0] STS_BAD_HDR    = 3'd2;
  localparam logic [2:0] STS_NO_MATCH   = 3'd3;
  localparam logic [2:0] STS_RETRY_DONE = 3'd4;
  localparam logic [2:0] STS_TIMEOUT    = 3'd5;

  // connection states
  localparam logic [3:0] LS_CLOSED     = 4'd0;
  localparam logic [3:0] LS_LISTEN     = 4'd1;
  localparam logic [3:0] LS_SYN_SENT   = 4'd2;
  localparam logic [3:0] LS_SYN_RCVD   = 4'd3;
  localparam logic [3:0] LS_ESTAB      = 4'd4;
  localparam logic [3:0] LS_FIN_WAIT1  = 4'd5;
  localparam logic [3:0] LS_FIN_WAIT2  = 4'd6;
  localparam logic [3:0] LS_CLOSE_WAIT = 4'd7;
  localparam logic [3:0] LS_CLOSING    = 4'd8;
  localparam logic [3:0] LS_LAST_ACK   = 4'd9;
  localparam logic [3:0] LS_TIME_WAIT  = 4'd10;

  // flag bit positions
  localparam int FLAG_FIN = 0;
  localparam int FLAG_SYN = 1;
  localparam int FLAG_RST = 2;
  localparam int FLAG_ACK = 4;

  localparam logic [15:0] MIN_SEG_LEN  = 16'd20;
  localparam logic [5:0]  MIN_HDR      = 6'd20;
  localparam logic [5:0]  MAX_HDR      = 6'd60;
  localparam logic [31:0] MIN_RTO      = 32'd1000;
  localparam int          RTTVAR_SHIFT = 6;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_LOCAL_PORT  = 3'd0;
  localparam logic [2:0] REG_PEER_PORT   = 3'd1;
  localparam logic [2:0] REG_ACTIVE      = 3'd2;
  localparam logic [2:0] REG_MAX_SEGMENT = 3'd3;
  localparam logic [2:0] REG_RETRY_LIMIT = 3'd4;

  localparam logic [15:0] MAX_SEGMENT_RESET = 16'd536;
  localparam logic [7:0]  RETRY_LIMIT_RESET = 8'd5;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  seg_flags;
    logic [15:0] seg_len;
    logic [5:0]  header_bytes;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] ack_number;
    logic [31:0] smoothed_rtt;
    logic [31:0] rtt_variance;
    logic [31:0] send_next;
    logic [3:0]  new_state;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  conn_state;
    logic [31:0] unacked_seq;
    logic [31:0] timeout_value;
    logic [31:0] resend_start;
    logic [15:0] resend_len;
  } result_t;

  typedef struct packed {
    logic [15:0] local_port;
    logic [15:0] peer_port;
    logic        connection_active;
    logic [15:0] max_segment;
    logic [7:0]  retry_limit;
  } cfg_t;

  // what the back end has to do with a queued transaction
  typedef enum logic [2:0] {
    OP_UPDATE,
    OP_DROP,
    OP_TIMEOUT,
    OP_LOAD,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [2:0]  drop_status;
    logic        fin;
    logic        syn;
    logic        rst;
    logic        ack;
    logic [31:0] ack_number;
    logic [31:0] timeout_value;
    logic [31:0] send_next;
    logic [3:0]  new_state;
  } entry_t;

endpackage

@@ src/tcpct_front.sv @@
// Front end: accepts input transactions, runs the segment checks and the
// timeout arithmetic, and hands a classified entry to the queue. Uses tcpct_pkg.
module tcpct_front import tcpct_pkg::*; (
  input  logic   item_valid,
  input  item_t  item,
  input  cfg_t   cfg,
  input  logic   queue_full,
  output logic   item_stall,
  output logic   push,
  output entry_t entry
);

  logic [31:0] rto_sum;

  assign item_stall = queue_full;
  assign push       = item_valid && !queue_full;
  assign rto_sum    = (item.smoothed_rtt >> 1) + (item.rtt_variance << RTTVAR_SHIFT);

  always_comb begin
    entry               = '0;
    entry.fin           = item.seg_flags[FLAG_FIN];
    entry.syn           = item.seg_flags[FLAG_SYN];
    entry.rst           = item.seg_flags[FLAG_RST];
    entry.ack           = item.seg_flags[FLAG_ACK];
    entry.ack_number    = item.ack_number;
    entry.send_next     = item.send_next;
    entry.timeout_value = (rto_sum < MIN_RTO) ? MIN_RTO : rto_sum;
    entry.new_state     = (item.new_state > LS_TIME_WAIT) ? LS_CLOSED : item.new_state;
    entry.drop_status   = STS_OK;
    entry.op            = OP_NONE;
    unique case (item.cmd)
      CMD_SEGMENT: begin
        if (item.seg_len < MIN_SEG_LEN) begin
          entry.op          = OP_DROP;
          entry.drop_status = STS_SHORT;
        end else if (item.header_bytes < MIN_HDR || item.header_bytes > MAX_HDR) begin
          entry.op          = OP_DROP;
          entry.drop_status = STS_BAD_HDR;
        end else if (!cfg.connection_active || item.source_port != cfg.peer_port ||
                     item.dest_port != cfg.local_port) begin
          entry.op          = OP_DROP;
          entry.drop_status = STS_NO_MATCH;
        end else begin
          entry.op = OP_UPDATE;
        end
      end
      CMD_TIMEOUT: entry.op = OP_TIMEOUT;
      CMD_LOCAL:   entry.op = OP_LOAD;
      CMD_NONE:    entry.op = OP_NONE;
      default:     entry.op = OP_NONE;
    endcase
  end

endmodule

@@ src/tcpct_queue.sv @@
// Short FIFO of classified entries between front and back end.
// Uses tcpct_pkg for the entry type.
module tcpct_queue import tcpct_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  input  logic   pop,
  output logic   full,
  output logic   empty,
  output entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  entry_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full  = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

@@ src/tcpct_back.sv @@
// Back end: applies queued entries to the connection state and holds the
// result register toward the output channel. Uses tcpct_pkg.
module tcpct_back import tcpct_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    queue_empty,
  input  entry_t  head,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result
);

  logic [3:0]  link_state;
  logic [31:0] oldest_unacked;
  logic [7:0]  retry_count;

  logic [3:0]  link_state_next;
  logic [31:0] oldest_unacked_next;
  logic [7:0]  retry_count_next;
  result_t     result_next;

  logic [7:0]  retry_inc;
  logic [31:0] outstanding;
  logic [15:0] resend_len;

  function automatic logic [3:0] step_state(logic [3:0] s, logic fin, logic syn,
                                            logic rs, logic ack);
    logic [3:0] n;
    n = s;
    case (s)
      LS_LISTEN:     if (syn) n = LS_SYN_RCVD;
      LS_SYN_SENT:   if (syn && ack) n = LS_ESTAB; else if (rs) n = LS_CLOSED;
      LS_SYN_RCVD:   if (ack) n = LS_ESTAB; else if (rs) n = LS_CLOSED;
      LS_ESTAB:      if (fin) n = LS_CLOSE_WAIT; else if (rs) n = LS_CLOSED;
      LS_FIN_WAIT1: begin
        if (fin && ack) n = LS_TIME_WAIT;
        else if (ack) n = LS_FIN_WAIT2;
        else if (rs) n = LS_CLOSED;
      end
      LS_FIN_WAIT2:  if (fin) n = LS_TIME_WAIT; else if (rs) n = LS_CLOSED;
      LS_CLOSE_WAIT: if (ack) n = LS_LAST_ACK; else if (rs) n = LS_CLOSED;
      LS_CLOSING:    if (ack) n = LS_TIME_WAIT; else if (rs) n = LS_CLOSED;
      LS_LAST_ACK:   if (ack || rs) n = LS_CLOSED;
      LS_TIME_WAIT:  if (rs) n = LS_CLOSED;
      default:       n = LS_CLOSED;
    endcase
    return n;
  endfunction

  assign pop         = !queue_empty && (!result_valid || !result_stall);
  assign retry_inc   = retry_count + 1'b1;
  assign outstanding = head.send_next - oldest_unacked;

  // only a positive, nonzero window counts as outstanding
  always_comb begin
    resend_len = '0;
    if (outstanding != '0 && !outstanding[31]) begin
      resend_len = (outstanding > {16'd0, cfg.max_segment}) ? cfg.max_segment
                                                            : outstanding[15:0];
    end
  end

  always_comb begin
    link_state_next     = link_state;
    oldest_unacked_next = oldest_unacked;
    retry_count_next    = retry_count;
    result_next         = '0;
    result_next.status  = STS_OK;
    case (head.op)
      OP_UPDATE: begin
        link_state_next = step_state(link_state, head.fin, head.syn, head.rst, head.ack);
        if (head.ack && head.ack_number > oldest_unacked) begin
          oldest_unacked_next = head.ack_number;
        end
        if (head.fin) begin
          retry_count_next = '0;
        end
      end
      OP_DROP: result_next.status = head.drop_status;
      OP_TIMEOUT: begin
        retry_count_next = retry_inc;
        if (retry_inc >= cfg.retry_limit) begin
          link_state_next    = LS_CLOSED;
          result_next.status = STS_RETRY_DONE;
        end else begin
          result_next.status        = STS_TIMEOUT;
          result_next.timeout_value = head.timeout_value;
          result_next.resend_len    = resend_len;
          result_next.resend_start  = (resend_len != '0) ? oldest_unacked : '0;
        end
      end
      OP_LOAD: begin
        link_state_next     = head.new_state;
        oldest_unacked_next = head.ack_number;
      end
      default: ;
    endcase
    result_next.conn_state  = link_state_next;
    result_next.unacked_seq = oldest_unacked_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      link_state     <= LS_CLOSED;
      oldest_unacked <= '0;
      retry_count    <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (pop) begin
        link_state     <= link_state_next;
        oldest_unacked <= oldest_unacked_next;
        retry_count    <= retry_count_next;
        result_valid   <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result <= result_next;
    end
  end

  a_retry_closes: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status == STS_RETRY_DONE) |-> result.conn_state == LS_CLOSED)
    else $error("retry close left connection open");

  a_idle_fields: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.status != STS_TIMEOUT) |->
      (result.timeout_value == '0 && result.resend_len == '0 && result.resend_start == '0))
    else $error("timeout fields set outside a timeout result");

  a_unacked_tracks: assert property (@(posedge clk) disable iff (rst)
    pop |=> result.unacked_seq == oldest_unacked && result.conn_state == link_state)
    else $error("result does not match tracked state");

endmodule

@@ src/tcp_connection_tracker.sv @@
// TCP connection tracker top level: configuration registers, front end,
// entry queue and back end. Uses tcpct_pkg, tcpct_front, tcpct_queue, tcpct_back.
//
// Usage:
//   item / item_valid / item_stall carry one event per transaction: a received
//   segment, a retransmit timeout or a local event that forces the state.
//   result / result_valid / result_stall return exactly one result per event,
//   in order. A transaction moves when valid is high and stall is low.
//   The APB port (registers at byte address 4*index) holds the ports, the
//   connection enable, the segment size cap and the retry limit; write it
//   only while no event is in flight. pready is always high.
// Flow: an accepted event is written into a queue slot and then into the
//   result register, together with result_valid; one event per cycle is
//   sustained while result_stall is low, since the back end applies each
//   entry to the connection state as it pops it.
// Reset (rst, synchronous): state closed, unacked number and retry count
//   zero, registers to their defaults, queue and result register empty.
// When the receiver stalls, the result is held, the queue absorbs up to
//   QUEUE_DEPTH_P further events, and then item_stall rises.
module tcp_connection_tracker import tcpct_pkg::*; #(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        item_valid,
  output logic        item_stall,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_stall,
  output result_t     result
);

  cfg_t       cfg;
  logic       push;
  logic       pop;
  logic       queue_full;
  logic       queue_empty;
  entry_t     push_entry;
  entry_t     head;
  logic [2:0] reg_index;

  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.local_port        <= '0;
      cfg.peer_port         <= '0;
      cfg.connection_active <= 1'b0;
      cfg.max_segment       <= MAX_SEGMENT_RESET;
      cfg.retry_limit       <= RETRY_LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      case (reg_index)
        REG_LOCAL_PORT:  cfg.local_port        <= pwdata[15:0];
        REG_PEER_PORT:   cfg.peer_port         <= pwdata[15:0];
        REG_ACTIVE:      cfg.connection_active <= pwdata[0];
        REG_MAX_SEGMENT: cfg.max_segment       <= pwdata[15:0];
        REG_RETRY_LIMIT: cfg.retry_limit       <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      REG_LOCAL_PORT:  prdata = {16'd0, cfg.local_port};
      REG_PEER_PORT:   prdata = {16'd0, cfg.peer_port};
      REG_ACTIVE:      prdata = {31'd0, cfg.connection_active};
      REG_MAX_SEGMENT: prdata = {16'd0, cfg.max_segment};
      REG_RETRY_LIMIT: prdata = {24'd0, cfg.retry_limit};
      default:         prdata = '0;
    endcase
  end

  tcpct_front u_front (
    .item_valid (item_valid),
    .item       (item),
    .cfg        (cfg),
    .queue_full (queue_full),
    .item_stall (item_stall),
    .push       (push),
    .entry      (push_entry)
  );

  tcpct_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .empty      (queue_empty),
    .head       (head)
  );

  tcpct_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .queue_empty  (queue_empty),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
